// ===== rtl/rma_pkg.sv =====
// ----------------------------------------------------------------------------
// rma_pkg
// Types and fixed widths shared by the ring moving-average filter.
// ----------------------------------------------------------------------------
package rma_pkg;

    localparam int DATA_W   = 16;
    localparam int BACK_W   = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 6;
    localparam int TOTAL_W  = 22;
    localparam int DIV_CNT_W = $clog2(TOTAL_W);

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_GET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_FILL  = 2'd3
    } t_mode;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ADDRD = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_POST  = 7'b0001000,
        S_GETRD = 7'b0010000,
        S_FILL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage

// ===== rtl/rma_ram.sv =====
// ----------------------------------------------------------------------------
// rma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ring_moving_average_top.sv =====
// ----------------------------------------------------------------------------
// ring_moving_average_top
// Moving-average filter over a ring of recent samples with add, get, clear
// and fill operations, one result transfer per input transfer.
// ----------------------------------------------------------------------------
// operation: add reads the oldest ring entry and then takes 22 steps of the shared
//   restoring divider; get takes the divider steps first and then one ring read;
//   fill writes one ring entry a cycle across the window; one item in flight.
// reset: synchronous, active low; ring reads as zero through per-entry valid
//   bits, pointer, total and average zero, window length 8. No clearing pass.
// ----------------------------------------------------------------------------
module ring_moving_average_top
    import rma_pkg::*;
#(
    parameter int MAX_WINDOW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_window_length,
    // input items
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [DATA_W-1:0]  i_sample,
    input  logic [BACK_W-1:0]         i_back_count,
    // result items
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [DATA_W-1:0]  o_average,
    output logic signed [DATA_W-1:0]  o_past_sample
);

    localparam int PW  = $clog2(MAX_WINDOW);
    localparam int LW  = $clog2(MAX_WINDOW + 1);
    localparam int XW  = LW + 1;
    localparam int CW  = (LW > CFG_W) ? LW : CFG_W;
    localparam int PRW = (LW + DATA_W + 1 > TOTAL_W) ? LW + DATA_W + 1 : TOTAL_W;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TOTAL_W - 1);

    // registers
    t_state                    r_state, n_state;
    t_mode                     r_mode, n_mode;
    logic [DATA_W-1:0]         r_sample, n_sample;
    logic [CFG_W-1:0]          r_wlen;
    logic [PW-1:0]             r_ptr, n_ptr;
    logic [TOTAL_W-1:0]        r_total, n_total;
    logic [DATA_W-1:0]         r_avg, n_avg;
    logic [MAX_WINDOW-1:0]     r_valid, n_valid;
    logic [TOTAL_W-1:0]        r_quo, n_quo;
    logic [LW-1:0]             r_rem, n_rem;
    logic [DIV_CNT_W-1:0]      r_cnt, n_cnt;
    logic                      r_neg, n_neg;
    logic [DATA_W-1:0]         r_past, n_past;
    logic [PW-1:0]             r_fill_idx, n_fill_idx;
    logic                      r_rd_valid;
    logic                      r_out_valid, n_out_valid;
    logic [DATA_W-1:0]         r_out_avg, n_out_avg;
    logic [DATA_W-1:0]         r_out_past, n_out_past;

    // combinational
    logic [LW-1:0]             w_len;
    logic [CW-1:0]             w_wlen_ext;
    logic [DATA_W-1:0]         w_rd_value;
    logic [TOTAL_W-1:0]        w_add_total;
    logic [TOTAL_W-1:0]        w_add_mag;
    logic [LW:0]               w_rem_sh;
    logic                      w_ge;
    logic [XW-1:0]             w_ptr_inc;
    logic [PW-1:0]             w_newest;
    logic [PW-1:0]             w_back_r;
    logic [XW-1:0]             w_idx_wide;
    logic [PW-1:0]             w_idx;
    logic [DATA_W-1:0]         w_sat_avg;
    logic signed [PRW-1:0]     w_fill_prod;
    logic                      w_out_free;

    // ring memory
    logic                      w_ram_we;
    logic [PW-1:0]             w_ram_waddr;
    logic [DATA_W-1:0]         w_ram_wdata;
    logic [PW-1:0]             w_ram_raddr;
    logic [DATA_W-1:0]         w_ram_rdata;

    rma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // active window: register saturated to 1..MAX_WINDOW
    assign w_wlen_ext = CW'(r_wlen);
    always_comb begin
        if (w_wlen_ext == '0) begin
            w_len = LW'(1);
        end else if (w_wlen_ext > CW'(MAX_WINDOW)) begin
            w_len = LW'(MAX_WINDOW);
        end else begin
            w_len = LW'(w_wlen_ext);
        end
    end

    // entries never written since reset or clear read as zero
    assign w_rd_value  = r_rd_valid ? w_ram_rdata : '0;

    assign w_add_total = r_total - {{(TOTAL_W-DATA_W){w_rd_value[DATA_W-1]}}, w_rd_value}
                       + {{(TOTAL_W-DATA_W){r_sample[DATA_W-1]}}, r_sample};
    assign w_add_mag   = w_add_total[TOTAL_W-1] ? (~w_add_total + TOTAL_W'(1)) : w_add_total;

    // one restoring division step
    assign w_rem_sh = {r_rem, r_quo[TOTAL_W-1]};
    assign w_ge     = (w_rem_sh >= (LW+1)'(w_len));

    assign w_ptr_inc = XW'(r_ptr) + XW'(1);

    // get: step back from the newest entry, wrapping to the top of the window
    assign w_newest  = (r_ptr == '0) ? PW'(w_len - LW'(1)) : (r_ptr - PW'(1));
    assign w_back_r  = PW'(r_rem);
    always_comb begin
        if (w_newest >= w_back_r) begin
            w_idx_wide = XW'(w_newest) - XW'(w_back_r);
        end else begin
            w_idx_wide = XW'(w_newest) + XW'(w_len) - XW'(w_back_r);
        end
    end
    assign w_idx = w_idx_wide[PW-1:0];

    // signed quotient, saturated to 16 bits
    always_comb begin
        if (r_neg) begin
            if (r_quo > TOTAL_W'(32768)) begin
                w_sat_avg = 16'h8000;
            end else begin
                w_sat_avg = ~r_quo[DATA_W-1:0] + DATA_W'(1);
            end
        end else begin
            if (r_quo > TOTAL_W'(32767)) begin
                w_sat_avg = 16'h7fff;
            end else begin
                w_sat_avg = r_quo[DATA_W-1:0];
            end
        end
    end

    assign w_fill_prod = $signed({{(PRW-DATA_W){r_sample[DATA_W-1]}}, r_sample})
                       * $signed({{(PRW-LW){1'b0}}, w_len});

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_sample    = r_sample;
        n_ptr       = r_ptr;
        n_total     = r_total;
        n_avg       = r_avg;
        n_valid     = r_valid;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_past      = r_past;
        n_fill_idx  = r_fill_idx;
        n_out_valid = r_out_valid;
        n_out_avg   = r_out_avg;
        n_out_past  = r_out_past;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_ptr;
        w_ram_wdata = r_sample;
        w_ram_raddr = r_ptr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = t_mode'(i_mode);
                    n_sample = i_sample;
                    n_past   = '0;
                    unique case (t_mode'(i_mode))
                        MODE_ADD: begin
                            // ring read of the oldest entry issued now
                            n_state = S_ADDRD;
                        end
                        MODE_GET: begin
                            n_quo   = TOTAL_W'(i_back_count);
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_neg   = 1'b0;
                            n_state = S_DIV;
                        end
                        MODE_CLEAR: begin
                            n_valid = '0;
                            n_ptr   = '0;
                            n_total = '0;
                            n_avg   = '0;
                            n_state = S_DONE;
                        end
                        MODE_FILL: begin
                            n_fill_idx = '0;
                            n_state    = S_FILL;
                        end
                    endcase
                end
            end
            S_ADDRD: begin
                n_total        = w_add_total;
                w_ram_we       = 1'b1;
                n_valid[r_ptr] = 1'b1;
                n_quo          = w_add_mag;
                n_rem          = '0;
                n_cnt          = '0;
                n_neg          = w_add_total[TOTAL_W-1];
                if (w_ptr_inc >= XW'(w_len)) begin
                    n_ptr = '0;
                end else begin
                    n_ptr = w_ptr_inc[PW-1:0];
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo = {r_quo[TOTAL_W-2:0], w_ge};
                n_rem = w_ge ? LW'(w_rem_sh - (LW+1)'(w_len)) : LW'(w_rem_sh);
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (r_mode == MODE_ADD) begin
                    n_avg   = w_sat_avg;
                    n_state = S_DONE;
                end else begin
                    w_ram_raddr = w_idx;
                    n_state     = S_GETRD;
                end
            end
            S_GETRD: begin
                n_past  = w_rd_value;
                n_state = S_DONE;
            end
            S_FILL: begin
                w_ram_we            = 1'b1;
                w_ram_waddr         = r_fill_idx;
                n_valid[r_fill_idx] = 1'b1;
                n_fill_idx          = r_fill_idx + PW'(1);
                if (r_fill_idx == PW'(w_len - LW'(1))) begin
                    n_ptr   = '0;
                    n_avg   = r_sample;
                    n_total = w_fill_prod[TOTAL_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_avg;
                    n_out_past  = r_past;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wlen      <= CFG_RESET;
            r_ptr       <= '0;
            r_total     <= '0;
            r_avg       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_total     <= n_total;
            r_avg       <= n_avg;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_wlen <= i_window_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_sample   <= n_sample;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_neg      <= n_neg;
        r_past     <= n_past;
        r_fill_idx <= n_fill_idx;
        r_out_avg  <= n_out_avg;
        r_out_past <= n_out_past;
        r_rd_valid <= r_valid[w_ram_raddr];
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_average     = r_out_avg;
    assign o_past_sample = r_out_past;

endmodule
